// ===== src/bps_pkg.sv =====
// bps_pkg: constants, types, codes and saturation helpers for the bezier path stepper
// used by every file of the block; depends on nothing
`timescale 1ns / 1ps

package bps_pkg;

  localparam int MAX_POINTS = 8;
  localparam int COORD_BITS = 32;
  localparam int IN_BITS    = 32;
  localparam int FRAC       = 16;
  localparam int T_W        = FRAC + 1;
  localparam int CFG_W      = 4;
  localparam int FUNC_W     = 2;
  localparam int PIDX_W     = 3;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int NCNT_W     = $clog2(MAX_POINTS + 1);
  localparam int SAT_W      = COORD_BITS + 34;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [IN_BITS-1:0]    in_coord_t;
  typedef logic [T_W-1:0]               tval_t;
  typedef logic [NCNT_W-1:0]            ncnt_t;
  typedef logic [IDX_W-1:0]             pidx_t;
  typedef coord_t                       coord_vec_t [MAX_POINTS];

  localparam tval_t T_ONE = tval_t'(1 << FRAC);

  localparam logic [SAT_W-1:0] CRD_MAX_U = (SAT_W'(1) << (COORD_BITS - 1)) - SAT_W'(1);
  localparam logic signed [SAT_W-1:0] CRD_MAX_W = $signed(CRD_MAX_U);
  localparam logic signed [SAT_W-1:0] CRD_MIN_W = $signed(~CRD_MAX_U);

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_EVAL  = 2'd1,
    FN_START = 2'd2,
    FN_STOP  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WB
  } top_state_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_LOAD,
    SQ_MIX,
    SQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic  start;
    ncnt_t n;
    tval_t t;
  } eval_req_t;

  typedef struct packed {
    logic   done;
    coord_t x;
    coord_t y;
    coord_t z;
  } eval_rsp_t;

  typedef struct packed {
    logic   en;
    pidx_t  idx;
    coord_t x;
    coord_t y;
    coord_t z;
  } pt_wr_t;

  function automatic coord_t sat_coord(input logic signed [SAT_W-1:0] v);
    coord_t r;
    priority if (v > CRD_MAX_W) begin
      r = coord_t'(CRD_MAX_W);
    end else if (v < CRD_MIN_W) begin
      r = coord_t'(CRD_MIN_W);
    end else begin
      r = coord_t'(v);
    end
    return r;
  endfunction

  function automatic coord_t in_coord(input in_coord_t v);
    return sat_coord(SAT_W'(v));
  endfunction

  function automatic ncnt_t used_points(input logic [CFG_W-1:0] c);
    ncnt_t r;
    priority if (int'(c) < 2) begin
      r = ncnt_t'(2);
    end else if (int'(c) > MAX_POINTS) begin
      r = ncnt_t'(MAX_POINTS);
    end else begin
      r = ncnt_t'(c);
    end
    return r;
  endfunction

endpackage

// ===== src/bps_ifs.sv =====
// bps_ifs: valid/ready channel interfaces for input items, results and configuration
// depends on bps_pkg for the coordinate and parameter types
`timescale 1ns / 1ps

interface bps_in_if;
  logic                         valid;
  logic                         ready;
  logic [bps_pkg::FUNC_W-1:0]   func;
  logic [bps_pkg::PIDX_W-1:0]   point_index;
  bps_pkg::in_coord_t           point_x;
  bps_pkg::in_coord_t           point_y;
  bps_pkg::in_coord_t           point_z;
  bps_pkg::tval_t               param_t;

  modport source (output valid, func, point_index, point_x, point_y, point_z, param_t,
                  input ready);
  modport sink (input valid, func, point_index, point_x, point_y, point_z, param_t,
                output ready);
endinterface

interface bps_out_if;
  logic            valid;
  logic            ready;
  bps_pkg::coord_t cur_x;
  bps_pkg::coord_t cur_y;
  bps_pkg::coord_t cur_z;
  bps_pkg::coord_t step_x;
  bps_pkg::coord_t step_y;
  bps_pkg::coord_t step_z;

  modport source (output valid, cur_x, cur_y, cur_z, step_x, step_y, step_z, input ready);
  modport sink (input valid, cur_x, cur_y, cur_z, step_x, step_y, step_z, output ready);
endinterface

interface bps_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bps_pkg::CFG_W-1:0] point_count;

  modport source (output valid, point_count, input ready);
  modport sink (input valid, point_count, output ready);
endinterface

// ===== src/bps_mix_unit.sv =====
// bps_mix_unit: shared interpolation unit, round(a*(1-t) + b*t) with halves rounded up
// one subtract, one signed multiply and two adds; depends on bps_pkg
`timescale 1ns / 1ps

module bps_mix_unit (
  input  bps_pkg::coord_t a,
  input  bps_pkg::coord_t b,
  input  bps_pkg::tval_t  t,
  output bps_pkg::coord_t m
);

  localparam int D_W   = bps_pkg::COORD_BITS + 1;
  localparam int ACC_W = bps_pkg::COORD_BITS + bps_pkg::T_W + 2;

  logic signed [D_W-1:0]          d;
  logic signed [bps_pkg::T_W:0]   t_s;
  logic signed [ACC_W-1:0]        prod;
  logic signed [ACC_W-1:0]        acc;

  // a + (b - a) * t, which equals the weighted sum exactly
  assign d    = D_W'(b) - D_W'(a);
  assign t_s  = $signed({1'b0, t});
  assign prod = ACC_W'(d) * ACC_W'(t_s);
  assign acc  = (ACC_W'(a) <<< bps_pkg::FRAC) + prod +
                (ACC_W'(1) <<< (bps_pkg::FRAC - 1));
  assign m    = acc[bps_pkg::COORD_BITS + bps_pkg::FRAC - 1:bps_pkg::FRAC];

endmodule

// ===== src/bps_point_store.sv =====
// bps_point_store: control point registers for x, y and z, written one point per beat
// all entries cleared at reset; depends on bps_pkg
`timescale 1ns / 1ps

module bps_point_store (
  input  logic                clk,
  input  logic                rst_n,
  input  bps_pkg::pt_wr_t     wr,
  output bps_pkg::coord_vec_t ctrl_x,
  output bps_pkg::coord_vec_t ctrl_y,
  output bps_pkg::coord_vec_t ctrl_z
);

  bps_pkg::coord_vec_t ctrl_x_r, ctrl_x_nxt;
  bps_pkg::coord_vec_t ctrl_y_r, ctrl_y_nxt;
  bps_pkg::coord_vec_t ctrl_z_r, ctrl_z_nxt;

  always_comb begin
    ctrl_x_nxt = ctrl_x_r;
    ctrl_y_nxt = ctrl_y_r;
    ctrl_z_nxt = ctrl_z_r;
    for (int k = 0; k < bps_pkg::MAX_POINTS; k++) begin
      if (wr.en && (wr.idx == bps_pkg::pidx_t'(k))) begin
        ctrl_x_nxt[k] = wr.x;
        ctrl_y_nxt[k] = wr.y;
        ctrl_z_nxt[k] = wr.z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < bps_pkg::MAX_POINTS; k++) begin
        ctrl_x_r[k] <= '0;
        ctrl_y_r[k] <= '0;
        ctrl_z_r[k] <= '0;
      end
    end else begin
      ctrl_x_r <= ctrl_x_nxt;
      ctrl_y_r <= ctrl_y_nxt;
      ctrl_z_r <= ctrl_z_nxt;
    end
  end

  assign ctrl_x = ctrl_x_r;
  assign ctrl_y = ctrl_y_r;
  assign ctrl_z = ctrl_z_r;

endmodule

// ===== src/bps_eval_seq.sv =====
// bps_eval_seq: de casteljau sequencer, one interpolation per cycle while mixing, through a work queue
// runs x, y then z on the shared bps_mix_unit; depends on bps_pkg and bps_mix_unit
`timescale 1ns / 1ps

module bps_eval_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  bps_pkg::eval_req_t  req,
  input  bps_pkg::coord_vec_t ctrl_x,
  input  bps_pkg::coord_vec_t ctrl_y,
  input  bps_pkg::coord_vec_t ctrl_z,
  output bps_pkg::eval_rsp_t  rsp
);

  bps_pkg::seq_state_t state_r, state_nxt;
  bps_pkg::axis_t      axis_r, axis_nxt;
  bps_pkg::ncnt_t      q_r, q_nxt;
  bps_pkg::ncnt_t      j_r, j_nxt;
  bps_pkg::ncnt_t      n_r, n_nxt;
  bps_pkg::tval_t      t_r, t_nxt;
  bps_pkg::coord_vec_t w_r, w_nxt;
  bps_pkg::coord_t     res_x_r, res_x_nxt;
  bps_pkg::coord_t     res_y_r, res_y_nxt;
  bps_pkg::coord_t     res_z_r, res_z_nxt;
  bps_pkg::coord_t     w_ext [bps_pkg::MAX_POINTS + 2];
  bps_pkg::coord_t     mix_m;
  logic                last_mix;

  bps_mix_unit u_mix (
    .a (w_r[0]),
    .b (w_r[1]),
    .t (t_r),
    .m (mix_m)
  );

  always_comb begin
    for (int k = 0; k < bps_pkg::MAX_POINTS; k++) begin
      w_ext[k] = w_r[k];
    end
    w_ext[bps_pkg::MAX_POINTS]     = '0;
    w_ext[bps_pkg::MAX_POINTS + 1] = '0;
  end

  assign last_mix = (j_r == (q_r - bps_pkg::ncnt_t'(1)));

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    q_nxt     = q_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    t_nxt     = t_r;
    w_nxt     = w_r;
    res_x_nxt = res_x_r;
    res_y_nxt = res_y_r;
    res_z_nxt = res_z_r;
    rsp.done  = 1'b0;
    rsp.x     = res_x_r;
    rsp.y     = res_y_r;
    rsp.z     = res_z_r;
    unique case (state_r)
      bps_pkg::SQ_IDLE: begin
        if (req.start) begin
          n_nxt     = req.n;
          t_nxt     = req.t;
          axis_nxt  = bps_pkg::AX_X;
          state_nxt = bps_pkg::SQ_LOAD;
        end
      end
      bps_pkg::SQ_LOAD: begin
        unique case (axis_r)
          bps_pkg::AX_X: w_nxt = ctrl_x;
          bps_pkg::AX_Y: w_nxt = ctrl_y;
          bps_pkg::AX_Z: w_nxt = ctrl_z;
          default:       w_nxt = ctrl_z;
        endcase
        q_nxt     = n_r;
        j_nxt     = bps_pkg::ncnt_t'(1);
        state_nxt = bps_pkg::SQ_MIX;
      end
      bps_pkg::SQ_MIX: begin
        if (!last_mix) begin
          // pop head, append new value at the tail of the level
          for (int k = 0; k < bps_pkg::MAX_POINTS; k++) begin
            w_nxt[k] = (bps_pkg::ncnt_t'(k) == (q_r - bps_pkg::ncnt_t'(1))) ?
                       mix_m : w_ext[k + 1];
          end
          j_nxt = j_r + bps_pkg::ncnt_t'(1);
        end else begin
          // last mix of a level also drops the leftover entry
          for (int k = 0; k < bps_pkg::MAX_POINTS; k++) begin
            w_nxt[k] = (bps_pkg::ncnt_t'(k) == (q_r - bps_pkg::ncnt_t'(2))) ?
                       mix_m : w_ext[k + 2];
          end
          q_nxt = q_r - bps_pkg::ncnt_t'(1);
          j_nxt = bps_pkg::ncnt_t'(1);
          if (q_r == bps_pkg::ncnt_t'(2)) begin
            unique case (axis_r)
              bps_pkg::AX_X: begin
                res_x_nxt = mix_m;
                axis_nxt  = bps_pkg::AX_Y;
                state_nxt = bps_pkg::SQ_LOAD;
              end
              bps_pkg::AX_Y: begin
                res_y_nxt = mix_m;
                axis_nxt  = bps_pkg::AX_Z;
                state_nxt = bps_pkg::SQ_LOAD;
              end
              default: begin
                res_z_nxt = mix_m;
                state_nxt = bps_pkg::SQ_DONE;
              end
            endcase
          end
        end
      end
      bps_pkg::SQ_DONE: begin
        rsp.done  = 1'b1;
        state_nxt = bps_pkg::SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bps_pkg::SQ_IDLE;
      axis_r  <= bps_pkg::AX_X;
      q_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      q_r     <= q_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    t_r     <= t_nxt;
    w_r     <= w_nxt;
    res_x_r <= res_x_nxt;
    res_y_r <= res_y_nxt;
    res_z_r <= res_z_nxt;
  end

endmodule

// ===== src/bezier_path_stepper_core.sv =====
// bezier_path_stepper_core: steps a point along a 3d bezier curve of up to eight points
// load, start and stop beats take effect at acceptance and the block is ready next cycle
// evaluate: result valid once the sequencer has run x, y then z (n points) and written back,
// one mix per cycle while mixing, on the single interpolation multiplier
// the next beat is taken once the result is in the output register
// reset (synchronous, rst_n low) clears points, current point and step, count to 2
`timescale 1ns / 1ps

module bezier_path_stepper_core (
  input logic       clk,
  input logic       rst_n,
  bps_in_if.sink    in_if,
  bps_out_if.source out_if,
  bps_cfg_if.sink   cfg_if
);

  bps_pkg::top_state_t        state_r, state_nxt;
  logic [bps_pkg::CFG_W-1:0]  point_count_r, point_count_nxt;
  bps_pkg::coord_t            now_x_r, now_x_nxt;
  bps_pkg::coord_t            now_y_r, now_y_nxt;
  bps_pkg::coord_t            now_z_r, now_z_nxt;
  bps_pkg::coord_t            diff_x_r, diff_x_nxt;
  bps_pkg::coord_t            diff_y_r, diff_y_nxt;
  bps_pkg::coord_t            diff_z_r, diff_z_nxt;
  bps_pkg::coord_t            cur_x_r, cur_x_nxt;
  bps_pkg::coord_t            cur_y_r, cur_y_nxt;
  bps_pkg::coord_t            cur_z_r, cur_z_nxt;
  bps_pkg::coord_t            step_x_r, step_x_nxt;
  bps_pkg::coord_t            step_y_r, step_y_nxt;
  bps_pkg::coord_t            step_z_r, step_z_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic                in_acc;
  logic                cfg_acc;
  bps_pkg::func_t      in_func;
  bps_pkg::pt_wr_t     pt_wr;
  bps_pkg::eval_req_t  req;
  bps_pkg::eval_rsp_t  rsp;
  bps_pkg::coord_vec_t ctrl_x;
  bps_pkg::coord_vec_t ctrl_y;
  bps_pkg::coord_vec_t ctrl_z;

  assign in_if.ready  = (state_r == bps_pkg::ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_if.ready;
  assign cfg_acc      = cfg_if.valid && cfg_if.ready;
  assign in_func      = bps_pkg::func_t'(in_if.func);

  assign pt_wr.en  = in_acc && (in_func == bps_pkg::FN_LOAD) &&
                     (int'(in_if.point_index) < bps_pkg::MAX_POINTS);
  assign pt_wr.idx = bps_pkg::pidx_t'(in_if.point_index);
  assign pt_wr.x   = bps_pkg::in_coord(in_if.point_x);
  assign pt_wr.y   = bps_pkg::in_coord(in_if.point_y);
  assign pt_wr.z   = bps_pkg::in_coord(in_if.point_z);

  assign req.start = in_acc && (in_func == bps_pkg::FN_EVAL) &&
                     (in_if.param_t <= bps_pkg::T_ONE);
  assign req.n     = bps_pkg::used_points(point_count_r);
  assign req.t     = in_if.param_t;

  bps_point_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (pt_wr),
    .ctrl_x (ctrl_x),
    .ctrl_y (ctrl_y),
    .ctrl_z (ctrl_z)
  );

  bps_eval_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .ctrl_x (ctrl_x),
    .ctrl_y (ctrl_y),
    .ctrl_z (ctrl_z),
    .rsp    (rsp)
  );

  assign point_count_nxt = cfg_acc ? cfg_if.point_count : point_count_r;

  always_comb begin
    state_nxt     = state_r;
    now_x_nxt     = now_x_r;
    now_y_nxt     = now_y_r;
    now_z_nxt     = now_z_r;
    diff_x_nxt    = diff_x_r;
    diff_y_nxt    = diff_y_r;
    diff_z_nxt    = diff_z_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    cur_z_nxt     = cur_z_r;
    step_x_nxt    = step_x_r;
    step_y_nxt    = step_y_r;
    step_z_nxt    = step_z_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      bps_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_func)
            bps_pkg::FN_LOAD: ;
            bps_pkg::FN_EVAL: begin
              if (req.start) begin
                state_nxt = bps_pkg::ST_EVAL;
              end
            end
            bps_pkg::FN_START: begin
              now_x_nxt = ctrl_x[0];
              now_y_nxt = ctrl_y[0];
              now_z_nxt = ctrl_z[0];
            end
            bps_pkg::FN_STOP: begin
              now_x_nxt  = ctrl_x[0];
              now_y_nxt  = ctrl_y[0];
              now_z_nxt  = ctrl_z[0];
              diff_x_nxt = '0;
              diff_y_nxt = '0;
              diff_z_nxt = '0;
            end
          endcase
        end
      end
      bps_pkg::ST_EVAL: begin
        if (rsp.done) begin
          state_nxt = bps_pkg::ST_WB;
        end
      end
      bps_pkg::ST_WB: begin
        // wait for the output register to free up
        if (!out_valid_r || out_if.ready) begin
          diff_x_nxt    = bps_pkg::sat_coord(bps_pkg::SAT_W'(rsp.x) -
                                             bps_pkg::SAT_W'(now_x_r));
          diff_y_nxt    = bps_pkg::sat_coord(bps_pkg::SAT_W'(rsp.y) -
                                             bps_pkg::SAT_W'(now_y_r));
          diff_z_nxt    = bps_pkg::sat_coord(bps_pkg::SAT_W'(rsp.z) -
                                             bps_pkg::SAT_W'(now_z_r));
          now_x_nxt     = rsp.x;
          now_y_nxt     = rsp.y;
          now_z_nxt     = rsp.z;
          cur_x_nxt     = rsp.x;
          cur_y_nxt     = rsp.y;
          cur_z_nxt     = rsp.z;
          step_x_nxt    = diff_x_nxt;
          step_y_nxt    = diff_y_nxt;
          step_z_nxt    = diff_z_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = bps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bps_pkg::ST_IDLE;
      point_count_r <= bps_pkg::CFG_W'(2);
      now_x_r       <= '0;
      now_y_r       <= '0;
      now_z_r       <= '0;
      diff_x_r      <= '0;
      diff_y_r      <= '0;
      diff_z_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      point_count_r <= point_count_nxt;
      now_x_r       <= now_x_nxt;
      now_y_r       <= now_y_nxt;
      now_z_r       <= now_z_nxt;
      diff_x_r      <= diff_x_nxt;
      diff_y_r      <= diff_y_nxt;
      diff_z_r      <= diff_z_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    cur_z_r  <= cur_z_nxt;
    step_x_r <= step_x_nxt;
    step_y_r <= step_y_nxt;
    step_z_r <= step_z_nxt;
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.cur_x  = cur_x_r;
  assign out_if.cur_y  = cur_y_r;
  assign out_if.cur_z  = cur_z_r;
  assign out_if.step_x = step_x_r;
  assign out_if.step_y = step_y_r;
  assign out_if.step_z = step_z_r;

  a_done_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> state_r == bps_pkg::ST_EVAL)
    else $error("sequencer finished outside an evaluation");

  a_out_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == bps_pkg::ST_WB)
    else $error("result beat raised without a write-back");

  a_bad_t_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_func == bps_pkg::FN_EVAL && in_if.param_t > bps_pkg::T_ONE)
    |=> state_r == bps_pkg::ST_IDLE)
    else $error("evaluate with t above one was not dropped");

endmodule

// ===== sim/testbench.sv =====
// testbench: self-checking regression for bezier_path_stepper_core, with its own curve predictor
// depends on bps_pkg (types, func codes) and the channel interfaces in bps_ifs
`timescale 1ns / 1ps

module testbench;

  localparam int  RAND_PER_PHASE = 36;
  localparam int  NUM_PHASES     = 12;
  localparam int  PRESSURE_PHASE = 9;
  localparam int  HOLD_CYCLES    = 400;
  localparam int  SETTLE_CYCLES  = 120;
  localparam int  CYCLE_LIMIT    = 1000000;
  localparam logic [63:0] BIAS   = 64'd1 << (bps_pkg::COORD_BITS - 1);
  localparam bps_pkg::in_coord_t IN_MAX = bps_pkg::in_coord_t'(32'h7fff_ffff);
  localparam bps_pkg::in_coord_t IN_MIN = bps_pkg::in_coord_t'(32'h8000_0000);

  typedef struct {
    bps_pkg::func_t             func;
    logic [bps_pkg::PIDX_W-1:0] idx;
    bps_pkg::in_coord_t         x;
    bps_pkg::in_coord_t         y;
    bps_pkg::in_coord_t         z;
    bps_pkg::tval_t             t;
  } path_beat_t;

  typedef struct {
    bps_pkg::coord_t cur_x;
    bps_pkg::coord_t cur_y;
    bps_pkg::coord_t cur_z;
    bps_pkg::coord_t step_x;
    bps_pkg::coord_t step_y;
    bps_pkg::coord_t step_z;
  } path_point_t;

  logic clk;
  logic rst_n;

  bps_in_if  in_ch ();
  bps_out_if out_ch ();
  bps_cfg_if cfg_ch ();

  bezier_path_stepper_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  path_beat_t  beats_to_send [$];
  path_point_t path_points_due [$];
  path_beat_t  next_beat;
  path_beat_t  taken_beat;

  // predictor state
  bps_pkg::coord_t pts_x [bps_pkg::MAX_POINTS];
  bps_pkg::coord_t pts_y [bps_pkg::MAX_POINTS];
  bps_pkg::coord_t pts_z [bps_pkg::MAX_POINTS];
  bps_pkg::coord_t pos_x, pos_y, pos_z;
  bps_pkg::coord_t delta_x, delta_y, delta_z;
  logic [bps_pkg::CFG_W-1:0] count_reg;

  int          queued_cnt;
  int          accepted_cnt;
  int          error_cnt;
  int          send_idle;
  int          recv_idle;
  int          cycle_cnt;
  logic        hold_arm;
  int          hold_cnt;
  logic        out_hold;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("error: %s", msg);
    error_cnt++;
  endtask

  function automatic bps_pkg::coord_t clamp_coord(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bps_pkg::COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      return bps_pkg::coord_t'(hi);
    end else if (v < lo) begin
      return bps_pkg::coord_t'(lo);
    end
    return bps_pkg::coord_t'(v);
  endfunction

  function automatic int curve_len(input logic [bps_pkg::CFG_W-1:0] c);
    if (int'(c) < 2) begin
      return 2;
    end else if (int'(c) > bps_pkg::MAX_POINTS) begin
      return bps_pkg::MAX_POINTS;
    end
    return int'(c);
  endfunction

  // a*(1-t) + b*t in the offset-binary domain, halves rounded up
  function automatic bps_pkg::coord_t lerp_q16(input bps_pkg::coord_t a,
                                               input bps_pkg::coord_t b,
                                               input bps_pkg::tval_t t);
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] acc;
    ua  = 64'($unsigned(a)) ^ BIAS;
    ub  = 64'($unsigned(b)) ^ BIAS;
    acc = ua * (64'(bps_pkg::T_ONE) - 64'(t)) + ub * 64'(t) + 64'd32768;
    return bps_pkg::coord_t'((acc >> bps_pkg::FRAC) ^ BIAS);
  endfunction

  function automatic bps_pkg::coord_t curve_point(input bps_pkg::coord_vec_t pts, input int n,
                                                  input bps_pkg::tval_t t);
    bps_pkg::coord_t w [bps_pkg::MAX_POINTS];
    w = pts;
    for (int lvl = 1; lvl < n; lvl++) begin
      for (int i = 0; i + lvl < n; i++) begin
        w[i] = lerp_q16(w[i], w[i + 1], t);
      end
    end
    return w[0];
  endfunction

  task automatic step_path(input path_beat_t b);
    path_point_t     p;
    bps_pkg::coord_t nx, ny, nz;
    int              n;
    case (b.func)
      bps_pkg::FN_LOAD: begin
        if (int'(b.idx) < bps_pkg::MAX_POINTS) begin
          pts_x[b.idx] = clamp_coord(longint'(b.x));
          pts_y[b.idx] = clamp_coord(longint'(b.y));
          pts_z[b.idx] = clamp_coord(longint'(b.z));
        end
      end
      bps_pkg::FN_START, bps_pkg::FN_STOP: begin
        pos_x = pts_x[0];
        pos_y = pts_y[0];
        pos_z = pts_z[0];
        if (b.func == bps_pkg::FN_STOP) begin
          delta_x = '0;
          delta_y = '0;
          delta_z = '0;
        end
      end
      default: begin
        if (b.t <= bps_pkg::T_ONE) begin
          n  = curve_len(count_reg);
          nx = curve_point(pts_x, n, b.t);
          ny = curve_point(pts_y, n, b.t);
          nz = curve_point(pts_z, n, b.t);
          delta_x = clamp_coord(longint'(nx) - longint'(pos_x));
          delta_y = clamp_coord(longint'(ny) - longint'(pos_y));
          delta_z = clamp_coord(longint'(nz) - longint'(pos_z));
          pos_x = nx;
          pos_y = ny;
          pos_z = nz;
          p.cur_x  = pos_x;
          p.cur_y  = pos_y;
          p.cur_z  = pos_z;
          p.step_x = delta_x;
          p.step_y = delta_y;
          p.step_z = delta_z;
          path_points_due.push_back(p);
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input bps_pkg::coord_t got,
                             input bps_pkg::coord_t want);
    if (got !== want) begin
      report_error($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken_beat.func = bps_pkg::func_t'(in_ch.func);
        taken_beat.idx  = in_ch.point_index;
        taken_beat.x    = in_ch.point_x;
        taken_beat.y    = in_ch.point_y;
        taken_beat.z    = in_ch.point_z;
        taken_beat.t    = in_ch.param_t;
        step_path(taken_beat);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle) begin
          next_beat = beats_to_send.pop_front();
          in_ch.func        <= next_beat.func;
          in_ch.point_index <= next_beat.idx;
          in_ch.point_x     <= next_beat.x;
          in_ch.point_y     <= next_beat.y;
          in_ch.point_z     <= next_beat.z;
          in_ch.param_t     <= next_beat.t;
          in_ch.valid       <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_arm && hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  assign out_hold = hold_arm && (hold_cnt < HOLD_CYCLES);

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !out_hold && ($urandom_range(99) >= recv_idle);
    end
  end

  // result monitor
  always @(posedge clk) begin
    path_point_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (path_points_due.size() == 0) begin
        report_error($sformatf("unexpected result cur %0d %0d %0d",
                               out_ch.cur_x, out_ch.cur_y, out_ch.cur_z));
      end else begin
        want = path_points_due.pop_front();
        check_field("cur_x", out_ch.cur_x, want.cur_x);
        check_field("cur_y", out_ch.cur_y, want.cur_y);
        check_field("cur_z", out_ch.cur_z, want.cur_z);
        check_field("step_x", out_ch.step_x, want.step_x);
        check_field("step_y", out_ch.step_y, want.step_y);
        check_field("step_z", out_ch.step_z, want.step_z);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("bezier_path_stepper_core regression: fail");
      $finish;
    end
  end

  function automatic bps_pkg::in_coord_t rand_coord();
    case ($urandom_range(5))
      0: return IN_MIN;
      1: return IN_MAX;
      2: return '0;
      3: return bps_pkg::in_coord_t'($urandom_range(0, 1 << 20)) -
                bps_pkg::in_coord_t'(1 << 19);
      default: return bps_pkg::in_coord_t'($urandom);
    endcase
  endfunction

  function automatic bps_pkg::tval_t rand_t();
    case ($urandom_range(9))
      0: return '0;
      1: return bps_pkg::T_ONE;
      2: return bps_pkg::tval_t'($urandom_range(65537, 131071));
      default: return bps_pkg::tval_t'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic path_beat_t make_beat(input bps_pkg::func_t f, input int idx,
                                           input bps_pkg::in_coord_t x,
                                           input bps_pkg::in_coord_t y,
                                           input bps_pkg::in_coord_t z,
                                           input int t);
    path_beat_t b;
    b.func = f;
    b.idx  = idx[bps_pkg::PIDX_W-1:0];
    b.x    = x;
    b.y    = y;
    b.z    = z;
    b.t    = bps_pkg::tval_t'(t);
    return b;
  endfunction

  function automatic path_beat_t rand_beat(input bps_pkg::func_t f);
    return make_beat(f, $urandom_range(7), rand_coord(), rand_coord(), rand_coord(),
                     int'(rand_t()));
  endfunction

  task automatic queue_beat(input path_beat_t b);
    beats_to_send.push_back(b);
    queued_cnt++;
  endtask

  // load the used points (sometimes one more at random), start, walk t upwards, then stop or restart
  task automatic queue_path(input int n);
    path_beat_t b;
    int         steps;
    int         t;
    for (int i = 0; i < n; i++) begin
      b = rand_beat(bps_pkg::FN_LOAD);
      b.idx = i[bps_pkg::PIDX_W-1:0];
      queue_beat(b);
    end
    if ($urandom_range(3) == 0) begin
      queue_beat(rand_beat(bps_pkg::FN_LOAD));
    end
    queue_beat(rand_beat(bps_pkg::FN_START));
    steps = $urandom_range(2, 8);
    t = 0;
    for (int i = 0; i < steps; i++) begin
      b = rand_beat(bps_pkg::FN_EVAL);
      b.t = bps_pkg::tval_t'(t);
      queue_beat(b);
      t = (i == steps - 2) ? 65536 : t + $urandom_range(0, 16000);
      if (t > 65536) begin
        t = 65536;
      end
    end
    queue_beat(rand_beat($urandom_range(1) ? bps_pkg::FN_STOP : bps_pkg::FN_START));
  endtask

  task automatic queue_directed();
    queue_beat(make_beat(bps_pkg::FN_EVAL, 0, 0, 0, 0, 0));
    queue_beat(make_beat(bps_pkg::FN_LOAD, 0, IN_MIN, IN_MAX, 0, 0));
    queue_beat(make_beat(bps_pkg::FN_LOAD, 1, IN_MAX, IN_MIN, -1, 0));
    queue_beat(make_beat(bps_pkg::FN_LOAD, 7, IN_MAX, IN_MAX, IN_MIN, 131071));
    queue_beat(make_beat(bps_pkg::FN_START, 0, 0, 0, 0, 0));
    queue_beat(make_beat(bps_pkg::FN_EVAL, 0, 0, 0, 0, 0));
    queue_beat(make_beat(bps_pkg::FN_EVAL, 0, 0, 0, 0, 65536));
    queue_beat(make_beat(bps_pkg::FN_EVAL, 0, 0, 0, 0, 0));
    queue_beat(make_beat(bps_pkg::FN_EVAL, 0, 0, 0, 0, 32768));
    queue_beat(make_beat(bps_pkg::FN_EVAL, 0, 0, 0, 0, 65537));
    queue_beat(make_beat(bps_pkg::FN_EVAL, 7, -1, -1, -1, 131071));
    queue_beat(make_beat(bps_pkg::FN_STOP, 0, 0, 0, 0, 0));
    queue_beat(make_beat(bps_pkg::FN_EVAL, 0, 0, 0, 0, 1));
    queue_beat(make_beat(bps_pkg::FN_LOAD, 1, 1, -1, 32'h7fff_0000, 65536));
    queue_beat(make_beat(bps_pkg::FN_START, 3, 5, 6, 7, 9));
    queue_beat(make_beat(bps_pkg::FN_EVAL, 0, 0, 0, 0, 65535));
    queue_beat(make_beat(bps_pkg::FN_LOAD, 6, 32'h0001_8000, -32768, 12345, 0));
    queue_beat(make_beat(bps_pkg::FN_STOP, 7, -1, -1, -1, 131071));
    queue_beat(make_beat(bps_pkg::FN_EVAL, 2, 0, 0, 0, 16384));
  endtask

  task automatic write_point_count(input logic [bps_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_ch.point_count <= v;
    cfg_ch.valid       <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    count_reg = v;
  endtask

  initial begin
    logic [bps_pkg::CFG_W-1:0] phase_counts [NUM_PHASES];
    int                        phase_start;
    phase_counts = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd1, 4'd7, 4'd9, 4'd4, 4'd6,
                     4'd8};
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = '0;
    in_ch.point_index = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    in_ch.param_t = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.point_count = '0;
    queued_cnt = 0;
    accepted_cnt = 0;
    error_cnt = 0;
    cycle_cnt = 0;
    send_idle = 0;
    recv_idle = 0;
    hold_arm = 1'b0;
    count_reg = 4'd2;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    delta_x = '0;
    delta_y = '0;
    delta_z = '0;
    for (int i = 0; i < bps_pkg::MAX_POINTS; i++) begin
      pts_x[i] = '0;
      pts_y[i] = '0;
      pts_z[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_point_count(phase_counts[ph]);
      if (ph < 4) begin
        send_idle <= 38;
        recv_idle <= 85;
      end else if (ph < 8) begin
        send_idle <= 85;
        recv_idle <= 38;
      end else begin
        send_idle <= 0;
        recv_idle <= 0;
      end
      if (ph == PRESSURE_PHASE) begin
        hold_arm <= 1'b1;
      end
      if (ph == 0) begin
        queue_directed();
      end
      phase_start = queued_cnt;
      while (queued_cnt - phase_start < RAND_PER_PHASE) begin
        if ($urandom_range(99) < 70) begin
          queue_path(curve_len(phase_counts[ph]));
        end else begin
          repeat ($urandom_range(1, 3))
            queue_beat(rand_beat(bps_pkg::func_t'($urandom_range(3))));
        end
      end
      do @(posedge clk); while (accepted_cnt != queued_cnt || path_points_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (error_cnt == 0) begin
      $display("bezier_path_stepper_core regression: pass");
    end else begin
      $display("bezier_path_stepper_core regression: fail");
    end
    $finish;
  end

endmodule
